FILE: hw/rtl/ntcs_pkg.sv
// ----------------------------------------------------------------------------
// ntcs_pkg
// Shared types and constants of the node table / counter sync block.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcs_pkg;

  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned REG_IDX_LSB = 2;

  localparam logic [15:0] FREE_HANDLE = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SYNC   = 3'd3,
    OP_FIND   = 3'd4
  } op_e;

  typedef enum logic {
    REG_LOCAL_SERIAL   = 1'b0,
    REG_SYNC_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] handle;
    logic [47:0] address;
    logic [6:0]  address_type;
    logic        central;
    logic [31:0] serial;
    logic [31:0] count;
    logic        updated;
  } slot_entry_t;

  localparam slot_entry_t SLOT_RESET = '{
    handle:       FREE_HANDLE,
    address:      48'd0,
    address_type: 7'd0,
    central:      1'b0,
    serial:       32'd0,
    count:        32'd0,
    updated:      1'b0
  };

endpackage

`default_nettype wire

FILE: hw/rtl/ntcs_if.sv
// ----------------------------------------------------------------------------
// ntcs_in_if / ntcs_out_if
// Valid/ready channels carrying one operation item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] link_handle;
  logic [47:0] peer_address;
  logic [6:0]  address_type;
  logic        central_role;
  logic [31:0] node_serial;
  logic [31:0] node_count;
  logic [31:0] local_count;

  modport source (
    output valid, opcode, link_handle, peer_address, address_type,
           central_role, node_serial, node_count, local_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, link_handle, peer_address, address_type,
           central_role, node_serial, node_count, local_count,
    output ready
  );
endinterface

interface ntcs_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  slot_index;
  logic [31:0] new_local_count;
  logic [3:0]  connection_total;

  modport source (
    output valid, status, slot_index, new_local_count, connection_total,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, new_local_count, connection_total,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/node_table_counter_sync_top.sv
// ----------------------------------------------------------------------------
// node_table_counter_sync_top
// Peer slot table with add/delete/update/find and counter sync.
// ----------------------------------------------------------------------------
// Every operation scans the whole slot table through the single read port of
// the slot memory, one slot per cycle, then commits its table write, if it
// has one, and loads the result register. A new item is taken only in the
// idle state, after the last one has committed. A result waiting in the
// output register does not hold off the next item until the next one
// finishes. Sync clears the updated marks during its scan using the write
// port.
// ----------------------------------------------------------------------------
`default_nettype none

module node_table_counter_sync_top #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ntcs_pkg::APB_AW-1:0]    paddr,
  input  wire logic [ntcs_pkg::APB_DW-1:0]    pwdata,
  output logic      [ntcs_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  ntcs_in_if.sink                             in_i,
  ntcs_out_if.source                          out_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Configuration
  logic [31:0] local_serial;
  logic [31:0] sync_threshold;

  ntcs_apb_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .local_serial_o   (local_serial),
    .sync_threshold_o (sync_threshold)
  );

  // Memory ports
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic                  clr_en;
  logic [IW-1:0]         wr_addr;
  ntcs_pkg::slot_entry_t wr_data;
  ntcs_pkg::slot_entry_t ent;

  ntcs_slot_mem #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .clr_en_i  (clr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (ent)
  );

  // Sequencer state
  ntcs_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q;
  logic [IW-1:0]    rd_idx_q;
  logic             rdv_q;

  // Captured item
  ntcs_pkg::op_e op_q;
  logic [15:0]   handle_q;
  logic [47:0]   addr_q;
  logic [6:0]    atype_q;
  logic          role_q;
  logic [31:0]   serial_q;
  logic [31:0]   count_q;
  logic [31:0]   lcount_q;

  // Scan results
  logic                  free_found_q, hf_found_q, hl_found_q, af_found_q;
  logic [IW-1:0]         free_idx_q, hf_idx_q, hl_idx_q, af_idx_q;
  ntcs_pkg::slot_entry_t hl_ent_q;
  logic [31:0]           best_sn_q, best_cnt_q;

  logic [CW-1:0] total_q, total_d;

  // Output register
  logic        out_valid_q;
  logic        status_q;
  logic [3:0]  slot_q;
  logic [31:0] newcount_q;
  logic [3:0]  conn_total_q;

  logic        accept;
  logic        commit;
  logic        scan_end;
  logic        handle_hit;
  logic        addr_hit;
  logic        status_d;
  logic [3:0]  slot_d;
  logic [31:0] newcount_d;
  logic [31:0] diff;

  assign in_i.ready = (state_q == ntcs_pkg::ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign scan_end   = (cnt_q == CW'(SLOTS));
  assign commit     = (state_q == ntcs_pkg::ST_DONE) & (~out_valid_q | out_o.ready);

  assign rd_en   = (state_q == ntcs_pkg::ST_SCAN) & ~scan_end;
  assign rd_addr = cnt_q[IW-1:0];

  assign handle_hit = (ent.handle == handle_q);
  assign addr_hit   = (ent.address == addr_q) & (ent.address_type == atype_q);

  // State machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntcs_pkg::ST_IDLE: if (accept)   state_d = ntcs_pkg::ST_SCAN;
      ntcs_pkg::ST_SCAN: if (scan_end) state_d = ntcs_pkg::ST_DONE;
      ntcs_pkg::ST_DONE: if (commit)   state_d = ntcs_pkg::ST_IDLE;
      default:                         state_d = ntcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rdv_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rdv_q    <= rd_en;
      rd_idx_q <= rd_addr;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == ntcs_pkg::ST_SCAN) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= ntcs_pkg::op_e'(in_i.opcode);
      handle_q <= in_i.link_handle;
      addr_q   <= in_i.peer_address;
      atype_q  <= in_i.address_type;
      role_q   <= in_i.central_role;
      serial_q <= in_i.node_serial;
      count_q  <= in_i.node_count;
      lcount_q <= in_i.local_count;
    end
  end

  // Scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      hf_found_q   <= 1'b0;
      hl_found_q   <= 1'b0;
      af_found_q   <= 1'b0;
    end else if (accept) begin
      free_found_q <= 1'b0;
      hf_found_q   <= 1'b0;
      hl_found_q   <= 1'b0;
      af_found_q   <= 1'b0;
    end else if (rdv_q) begin
      if (ent.handle == ntcs_pkg::FREE_HANDLE) free_found_q <= 1'b1;
      if (handle_hit) begin
        hf_found_q <= 1'b1;
        hl_found_q <= 1'b1;
      end
      if (addr_hit) af_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_sn_q  <= local_serial;
      best_cnt_q <= in_i.local_count;
    end else if (rdv_q) begin
      if (ent.handle == ntcs_pkg::FREE_HANDLE && !free_found_q) free_idx_q <= rd_idx_q;
      if (handle_hit && !hf_found_q) hf_idx_q <= rd_idx_q;
      if (handle_hit) begin
        hl_idx_q <= rd_idx_q;
        hl_ent_q <= ent;
      end
      if (addr_hit && !af_found_q) af_idx_q <= rd_idx_q;
      if (ent.updated && (best_sn_q > ent.serial)) begin
        best_sn_q  <= ent.serial;
        best_cnt_q <= ent.count;
      end
    end
  end

  // Commit: result, table write and link total
  assign diff = (lcount_q > best_cnt_q) ? (lcount_q - best_cnt_q) : (best_cnt_q - lcount_q);

  always_comb begin
    status_d   = 1'b1;
    slot_d     = 4'(SLOTS);
    newcount_d = lcount_q;
    total_d    = total_q;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    wr_addr    = rd_idx_q;
    wr_data    = ent;
    wr_data.updated = 1'b0;

    // sync clears marks during the scan
    if (rdv_q && op_q == ntcs_pkg::OP_SYNC && ent.updated) begin
      wr_en = 1'b1;
    end

    unique case (op_q)
      ntcs_pkg::OP_ADD: begin
        if (free_found_q) begin
          status_d = 1'b0;
          slot_d   = 4'(free_idx_q);
          if (commit) begin
            wr_en   = 1'b1;
            wr_addr = free_idx_q;
            wr_data = '{handle: handle_q, address: addr_q, address_type: atype_q,
                        central: role_q, serial: serial_q, count: count_q,
                        updated: 1'b0};
          end
        end
        if (total_q < CW'(SLOTS)) total_d = total_q + CW'(1);
      end
      ntcs_pkg::OP_DELETE: begin
        if (hf_found_q) begin
          status_d = 1'b0;
          slot_d   = 4'(hf_idx_q);
          if (commit) begin
            clr_en  = 1'b1;
            wr_addr = hf_idx_q;
          end
        end
        if (total_q != '0) total_d = total_q - CW'(1);
      end
      ntcs_pkg::OP_UPDATE: begin
        if (hl_found_q) begin
          status_d = 1'b0;
          slot_d   = 4'(hl_idx_q);
          if (commit) begin
            wr_en           = 1'b1;
            wr_addr         = hl_idx_q;
            wr_data         = hl_ent_q;
            wr_data.serial  = serial_q;
            wr_data.count   = count_q;
            wr_data.updated = 1'b1;
          end
        end
      end
      ntcs_pkg::OP_SYNC: begin
        status_d = 1'b0;
        if (local_serial > best_sn_q && diff > sync_threshold) begin
          newcount_d = best_cnt_q;
        end
      end
      ntcs_pkg::OP_FIND: begin
        if (af_found_q) begin
          status_d = 1'b0;
          slot_d   = 4'(af_idx_q);
        end
      end
      default: ;
    endcase

    if (!commit) total_d = total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q     <= status_d;
      slot_q       <= slot_d;
      newcount_q   <= newcount_d;
      conn_total_q <= 4'(total_d);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = status_q;
  assign out_o.slot_index       = slot_q;
  assign out_o.new_local_count  = newcount_q;
  assign out_o.connection_total = conn_total_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ntcs_apb_regs.sv
// ----------------------------------------------------------------------------
// ntcs_apb_regs
// APB register file: local serial and sync threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcs_apb_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ntcs_pkg::APB_AW-1:0]    paddr,
  input  wire logic [ntcs_pkg::APB_DW-1:0]    pwdata,
  output logic      [ntcs_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  output logic      [31:0]                    local_serial_o,
  output logic      [31:0]                    sync_threshold_o
);

  logic [31:0]        local_serial_q;
  logic [31:0]        sync_threshold_q;
  logic               wr_en;
  ntcs_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = ntcs_pkg::reg_idx_e'(paddr[ntcs_pkg::REG_IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_serial_q   <= '0;
      sync_threshold_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        ntcs_pkg::REG_LOCAL_SERIAL:   local_serial_q   <= pwdata;
        ntcs_pkg::REG_SYNC_THRESHOLD: sync_threshold_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ntcs_pkg::REG_LOCAL_SERIAL:   prdata = local_serial_q;
      ntcs_pkg::REG_SYNC_THRESHOLD: prdata = sync_threshold_q;
    endcase
  end

  assign local_serial_o   = local_serial_q;
  assign sync_threshold_o = sync_threshold_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ntcs_slot_mem.sv
// ----------------------------------------------------------------------------
// ntcs_slot_mem
// Slot table memory, one read and one write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcs_slot_mem #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IW    = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  rd_en_i,
  input  wire logic [IW-1:0]         rd_addr_i,
  input  wire logic                  wr_en_i,
  input  wire logic                  clr_en_i,
  input  wire logic [IW-1:0]         wr_addr_i,
  input  ntcs_pkg::slot_entry_t      wr_data_i,
  output ntcs_pkg::slot_entry_t      rd_data_o
);

  ntcs_pkg::slot_entry_t mem_q [SLOTS];
  ntcs_pkg::slot_entry_t rd_data_q;
  logic [SLOTS-1:0]      valid_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entries never written (or freed) read as the reset slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (clr_en_i) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : ntcs_pkg::SLOT_RESET;

endmodule

`default_nettype wire

FILE: sim/node_table_counter_sync_top_tb.sv
// ----------------------------------------------------------------------------
// node_table_counter_sync_top_tb
// Self-checking bench for the peer slot table with counter sync. A model of
// the table predicts one result per accepted operation, and each result
// coming out is compared in order. Directed operations come first. Random
// phases follow over several register settings, with random stalls on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------

module node_table_counter_sync_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS          = 8;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = SLOTS + 6;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] handle;
    logic [47:0] address;
    logic [6:0]  atype;
    logic        central;
    logic [31:0] serial;
    logic [31:0] count;
    logic [31:0] lcount;
  } op_item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  slot;
    logic [31:0] new_count;
    logic [3:0]  total;
  } result_t;

  class peer_table_scoreboard;
    ntcs_pkg::slot_entry_t slots [SLOTS];
    int unsigned link_total;
    logic [31:0] local_serial;
    logic [31:0] sync_threshold;
    result_t     expected_results [$];
    int unsigned mismatch_count;

    function new();
      foreach (slots[i]) slots[i] = ntcs_pkg::SLOT_RESET;
      link_total     = 0;
      local_serial   = '0;
      sync_threshold = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(ntcs_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        ntcs_pkg::REG_LOCAL_SERIAL:   local_serial = value;
        ntcs_pkg::REG_SYNC_THRESHOLD: sync_threshold = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted operation to the table and queue its result.
    function void note_op(op_item_t it);
      result_t     r;
      int unsigned pick;
      logic [31:0] best_sn;
      logic [31:0] best_cnt;
      logic [31:0] diff;
      pick        = SLOTS;
      r.new_count = it.lcount;
      case (it.opcode)
        ntcs_pkg::OP_ADD: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slots[i].handle == ntcs_pkg::FREE_HANDLE) begin
              slots[i].handle       = it.handle;
              slots[i].address      = it.address;
              slots[i].address_type = it.atype;
              slots[i].central      = it.central;
              slots[i].serial       = it.serial;
              slots[i].count        = it.count;
              slots[i].updated      = 1'b0;
              pick = i;
              break;
            end
          end
          // total moves even when no slot is free, capped at SLOTS
          if (link_total < SLOTS) link_total++;
        end
        ntcs_pkg::OP_DELETE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slots[i].handle == it.handle) begin
              slots[i] = ntcs_pkg::SLOT_RESET;
              pick = i;
              break;
            end
          end
          if (link_total > 0) link_total--;
        end
        ntcs_pkg::OP_UPDATE: begin
          // last matching slot wins
          for (int i = 0; i < SLOTS; i++)
            if (slots[i].handle == it.handle) pick = i;
          if (pick < SLOTS) begin
            slots[pick].serial  = it.serial;
            slots[pick].count   = it.count;
            slots[pick].updated = 1'b1;
          end
        end
        ntcs_pkg::OP_SYNC: begin
          best_sn  = local_serial;
          best_cnt = it.lcount;
          for (int i = 0; i < SLOTS; i++) begin
            if (slots[i].updated) begin
              slots[i].updated = 1'b0;
              if (best_sn > slots[i].serial) begin
                best_sn  = slots[i].serial;
                best_cnt = slots[i].count;
              end
            end
          end
          if (local_serial > best_sn) begin
            diff = (it.lcount > best_cnt) ? it.lcount - best_cnt : best_cnt - it.lcount;
            if (diff > sync_threshold) r.new_count = best_cnt;
          end
        end
        ntcs_pkg::OP_FIND: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slots[i].address == it.address && slots[i].address_type == it.atype) begin
              pick = i;
              break;
            end
          end
        end
        default: ;
      endcase
      r.status = (pick == SLOTS);
      if (it.opcode == ntcs_pkg::OP_SYNC) r.status = 1'b0;
      r.slot  = 4'(pick);
      r.total = 4'(link_total);
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result item with none pending: st=%0d slot=%0d cnt=%08h tot=%0d",
                   $realtime, got.status, got.slot, got.new_count, got.total);
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status || got.slot !== exp.slot ||
          got.new_count !== exp.new_count || got.total !== exp.total) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch exp st=%0d slot=%0d cnt=%08h tot=%0d",
                   $realtime, exp.status, exp.slot, exp.new_count, exp.total,
                   " / got st=%0d slot=%0d cnt=%08h tot=%0d",
                   got.status, got.slot, got.new_count, got.total);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ntcs_pkg::APB_AW-1:0] paddr;
  logic [ntcs_pkg::APB_DW-1:0] pwdata;
  logic [ntcs_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  ntcs_in_if  in_if ();
  ntcs_out_if out_if ();

  peer_table_scoreboard sb = new();

  bit no_idle;
  bit hold_req;

  logic [47:0] addr_pool [4];
  logic [6:0]  type_pool [4];

  node_table_counter_sync_top #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Both channels are sampled here, before any edge update lands.
  always @(posedge clk_i) begin : monitor
    op_item_t seen;
    result_t  got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen = '{in_if.opcode, in_if.link_handle, in_if.peer_address, in_if.address_type,
                 in_if.central_role, in_if.node_serial, in_if.node_count,
                 in_if.local_count};
        sb.note_op(seen);
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.status, out_if.slot_index, out_if.new_local_count,
                out_if.connection_total};
        sb.check_result(got);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  function automatic op_item_t rand_item();
    op_item_t    it;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 25)      it.opcode = ntcs_pkg::OP_ADD;
    else if (r < 43) it.opcode = ntcs_pkg::OP_DELETE;
    else if (r < 68) it.opcode = ntcs_pkg::OP_UPDATE;
    else if (r < 80) it.opcode = ntcs_pkg::OP_SYNC;
    else if (r < 95) it.opcode = ntcs_pkg::OP_FIND;
    else             it.opcode = ntcs_pkg::OP_FIND + 3'($urandom_range(1, 3));
    r = $urandom_range(99);
    if (r < 80)      it.handle = 16'($urandom_range(0, 9));
    else if (r < 85) it.handle = ntcs_pkg::FREE_HANDLE;
    else             it.handle = 16'($urandom);
    k = $urandom_range(0, 3);
    r = $urandom_range(99);
    if (r < 70) begin
      it.address = addr_pool[k];
      it.atype   = type_pool[k];
    end else if (r < 80) begin
      it.address = '0;
      it.atype   = '0;
    end else begin
      it.address = 48'({$urandom, $urandom});
      it.atype   = 7'($urandom);
    end
    it.central = 1'($urandom);
    it.serial  = ($urandom_range(99) < 40) ? 32'($urandom_range(0, 15)) : 32'($urandom);
    it.count   = ($urandom_range(99) < 30) ? 32'($urandom_range(0, 2000)) : 32'($urandom);
    it.lcount  = ($urandom_range(99) < 30) ? 32'($urandom_range(0, 2000)) : 32'($urandom);
    return it;
  endfunction

  function automatic op_item_t shape_item(logic [2:0] op, logic [15:0] h,
                                          logic [47:0] a, logic [6:0] t);
    op_item_t it;
    it         = rand_item();
    it.opcode  = op;
    it.handle  = h;
    it.address = a;
    it.atype   = t;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_op(input op_item_t it);
    if (!no_idle && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= it.opcode;
    in_if.link_handle  <= it.handle;
    in_if.peer_address <= it.address;
    in_if.address_type <= it.atype;
    in_if.central_role <= it.central;
    in_if.node_serial  <= it.serial;
    in_if.node_count   <= it.count;
    in_if.local_count  <= it.lcount;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the bus idle before returning so writes never abut.
  task automatic apb_write(input ntcs_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ntcs_pkg::APB_AW'(int'(idx) << ntcs_pkg::REG_IDX_LSB);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    op_item_t   it;
    logic [2:0] bad_op;
    send_op(shape_item(ntcs_pkg::OP_FIND, 16'h0000, '0, '0));     // zero address hits free slot
    send_op(shape_item(ntcs_pkg::OP_DELETE, 16'h1234, '0, '0));   // miss, total held at zero
    send_op(shape_item(ntcs_pkg::OP_UPDATE, 16'h1234, '0, '0));   // miss
    it         = shape_item(ntcs_pkg::OP_ADD, 16'h0000, '1, 7'h7F);
    it.central = 1'b1;
    it.serial  = '1;
    it.count   = '1;
    send_op(it);
    send_op(shape_item(ntcs_pkg::OP_ADD, ntcs_pkg::FREE_HANDLE, '0, '0));     // slot stays free
    send_op(shape_item(ntcs_pkg::OP_UPDATE, ntcs_pkg::FREE_HANDLE, '0, '0));  // marks last free
    for (int h = 1; h <= 7; h++)
      send_op(shape_item(ntcs_pkg::OP_ADD, 16'(h), addr_pool[h % 4], type_pool[h % 4]));
    // table full
    send_op(shape_item(ntcs_pkg::OP_ADD, 16'h0008, addr_pool[0], type_pool[0]));
    send_op(shape_item(ntcs_pkg::OP_FIND, 16'h0000, '1, 7'h7F));
    send_op(shape_item(ntcs_pkg::OP_FIND, 16'h0000, '1, 7'h00));  // type differs
    send_op(shape_item(ntcs_pkg::OP_DELETE, 16'h0002, '0, '0));
    // duplicate handle
    send_op(shape_item(ntcs_pkg::OP_ADD, 16'h0005, addr_pool[1], type_pool[1]));
    send_op(shape_item(ntcs_pkg::OP_UPDATE, 16'h0005, '0, '0));
    send_op(shape_item(ntcs_pkg::OP_DELETE, 16'h0005, '0, '0));
    send_op(shape_item(ntcs_pkg::OP_SYNC, 16'h0000, '0, '0));
    bad_op = ntcs_pkg::OP_FIND + 3'd1;
    repeat (3) begin
      send_op(shape_item(bad_op, 16'h0000, '0, '0));
      bad_op++;
    end
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) send_op(rand_item());
  endtask

  task automatic set_regs(input logic [31:0] serial, input logic [31:0] threshold);
    settle();
    apb_write(ntcs_pkg::REG_LOCAL_SERIAL, serial);
    apb_write(ntcs_pkg::REG_SYNC_THRESHOLD, threshold);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= ntcs_pkg::OP_ADD;
    in_if.link_handle  <= '0;
    in_if.peer_address <= '0;
    in_if.address_type <= '0;
    in_if.central_role <= 1'b0;
    in_if.node_serial  <= '0;
    in_if.node_count   <= '0;
    in_if.local_count  <= '0;
    foreach (addr_pool[k]) begin
      addr_pool[k] = 48'({$urandom, $urandom});
      type_pool[k] = 7'($urandom);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    set_regs('1, '0);
    run_random(180);

    // output held off while items keep coming
    set_regs(32'h8000_0000, 32'd1000);
    hold_req = 1'b1;
    run_random(180);

    set_regs(32'($urandom), 32'($urandom));
    no_idle = 1'b1;
    run_random(180);
    no_idle = 1'b0;

    set_regs('1, '1);
    run_random(180);

    set_regs('0, '0);
    run_random(180);

    set_regs(32'($urandom), 32'd500);
    run_random(200);

    settle();
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("node_table_counter_sync_top_tb: done, clean");
    else
      $display("node_table_counter_sync_top_tb: done, errors");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("node_table_counter_sync_top_tb: done, errors");
    $finish;
  end

endmodule
